// ===== rtl/lse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types, sizes and codes for the LEGv8 subset execute unit.
// ----------------------------------------------------------------------------
package lse_pkg;

	// storage sizes
	localparam int DATA_WORDS = 32;
	localparam int NUM_REGS   = 32;
	localparam int DMEM_AW    = $clog2(DATA_WORDS);
	localparam int RF_AW      = $clog2(NUM_REGS);

	// power-up clearing sweep covers the larger of the two stores
	localparam int CLR_WORDS = (DATA_WORDS > NUM_REGS) ? DATA_WORDS : NUM_REGS;
	localparam int CLR_AW    = $clog2(CLR_WORDS);

	// configuration reset values and pc step
	localparam logic [15:0] START_RESET = 16'd200;
	localparam logic [15:0] BASE_RESET  = 16'd100;
	localparam logic [15:0] PC_STEP     = 16'd4;

	// configuration register index, taken from paddr[2]
	localparam logic CFG_IDX_START = 1'b0;
	localparam logic CFG_IDX_BASE  = 1'b1;

	// instruction kinds
	typedef enum logic [2:0] {
		KIND_ADDI    = 3'd0,
		KIND_ADD     = 3'd1,
		KIND_SUBI    = 3'd2,
		KIND_SUB     = 3'd3,
		KIND_LDUR    = 3'd4,
		KIND_STUR    = 3'd5,
		KIND_B       = 3'd6,
		KIND_PRELOAD = 3'd7
	} kind_t;

	// execute result for one instruction
	typedef struct packed {
		logic [15:0]        pc_next;
		logic               reg_wr;
		logic [RF_AW-1:0]   wr_index;
		logic [31:0]        alu_value;
		logic               is_load;
		logic               fault;
		logic               dmem_we;
		logic               dmem_re;
		logic [DMEM_AW-1:0] dmem_addr;
		logic [31:0]        dmem_wdata;
	} exec_res_t;

endpackage
`default_nettype wire

// ===== rtl/lse_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_ram
// Generic single-write, single-read RAM with registered read data.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module lse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read; a read of the address written returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lse_exec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_exec
// Combinational execute step: ALU, data address check, memory controls
// and next program counter for one instruction.
// ----------------------------------------------------------------------------
module lse_exec (
	input  wire logic [2:0]              kind,
	input  wire logic [lse_pkg::RF_AW-1:0] dest_reg,
	input  wire logic [12:0]             immediate,
	input  wire logic [15:0]             branch_target,
	input  wire logic [31:0]             data_value,
	input  wire logic [31:0]             opa,
	input  wire logic [31:0]             opb,
	input  wire logic [15:0]             pc,
	input  wire logic [15:0]             data_base,
	output lse_pkg::exec_res_t           res
);
	import lse_pkg::*;

	kind_t       k;
	logic [31:0] imm32;
	logic        sub;
	logic [31:0] bop;
	logic [31:0] alu;
	logic [33:0] addr;
	logic [31:0] word;
	logic        mem_fault;
	logic        pre_fault;

	assign k = kind_t'(kind);

	// add or subtract with one adder
	always_comb begin
		imm32 = {{19{immediate[12]}}, immediate};
		sub   = (k == KIND_SUBI) || (k == KIND_SUB);
		bop   = ((k == KIND_ADDI) || (k == KIND_SUBI)) ? imm32 : opb;
		alu   = opa + (sub ? ~bop : bop) + {31'b0, sub};
	end

	// exact data address, then word index range check
	always_comb begin
		addr = {{2{opa[31]}}, opa} + {{21{immediate[12]}}, immediate}
			- {18'b0, data_base};
		word = addr[33:2];
		mem_fault = addr[33] || (word >= 32'(DATA_WORDS));
		pre_fault = immediate[12] || ({20'b0, immediate[11:0]} >= 32'(DATA_WORDS));
	end

	// decode kind into writes, memory controls and next pc
	always_comb begin
		res            = '0;
		res.pc_next    = pc + PC_STEP;
		res.dmem_addr  = addr[2 +: DMEM_AW];
		res.dmem_wdata = opb;
		case (k)
			KIND_ADDI, KIND_ADD, KIND_SUBI, KIND_SUB: begin
				res.reg_wr = 1'b1;
			end
			KIND_LDUR: begin
				res.fault   = mem_fault;
				res.reg_wr  = !mem_fault;
				res.is_load = !mem_fault;
				res.dmem_re = !mem_fault;
			end
			KIND_STUR: begin
				res.fault   = mem_fault;
				res.dmem_we = !mem_fault;
			end
			KIND_B: begin
				res.pc_next = branch_target;
			end
			KIND_PRELOAD: begin
				res.pc_next    = pc;
				res.fault      = pre_fault;
				res.dmem_we    = !pre_fault;
				res.dmem_addr  = immediate[DMEM_AW-1:0];
				res.dmem_wdata = data_value;
			end
			default: begin
				res.pc_next = pc;
			end
		endcase
		res.wr_index  = res.reg_wr ? dest_reg : '0;
		res.alu_value = (res.reg_wr && !res.is_load) ? alu : '0;
	end

endmodule
`default_nettype wire

// ===== rtl/legv8_subset_execute.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted instruction passes through the input stage and then the result stage.
// Throughput: one instruction per cycle unless the result channel stalls; the register
// file read, execute step and data memory access are spread over the input and result stages.
// Reset: after arst_n releases, a clearing sweep over max(DATA_WORDS, NUM_REGS)
// words zeroes the register file and data memory; input stalls meanwhile.
// Configuration writes are taken at any time, including during the sweep.
// ----------------------------------------------------------------------------
// legv8_subset_execute
// Executes one decoded LEGv8 subset instruction per transaction against a
// register file, a word data memory and a program counter.
// ----------------------------------------------------------------------------
module legv8_subset_execute (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// instruction channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  kind,
	input  wire logic [4:0]  dest_reg,
	input  wire logic [4:0]  src_reg,
	input  wire logic [4:0]  second_reg,
	input  wire logic signed [12:0] immediate,
	input  wire logic [15:0] branch_target,
	input  wire logic signed [31:0] data_value,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [15:0] pc_after,
	output logic             reg_written,
	output logic      [4:0]  written_index,
	output logic signed [31:0] written_value,
	output logic             access_fault
);
	import lse_pkg::*;

	// configuration and architectural registers
	logic [15:0] start_q;
	logic [15:0] base_q;
	logic [15:0] pc_q;
	logic        cfg_wr;

	// clearing sweep
	logic              clearing_q;
	logic [CLR_AW-1:0] clr_cnt_q;

	// handshake
	logic in_accept;
	logic adv12;
	logic s2_free;

	// input stage
	logic             s1_valid;
	logic [2:0]       s1_kind;
	logic [RF_AW-1:0] s1_dest;
	logic [RF_AW-1:0] s1_src;
	logic [RF_AW-1:0] s1_breg;
	logic [12:0]      s1_imm;
	logic [15:0]      s1_target;
	logic [31:0]      s1_data;
	logic             patch_a_q;
	logic             patch_b_q;
	logic [31:0]      patch_a_val_q;
	logic [31:0]      patch_b_val_q;

	// result stage
	logic             s2_valid;
	logic [15:0]      s2_pc;
	logic             s2_wr;
	logic [RF_AW-1:0] s2_idx;
	logic [31:0]      s2_val;
	logic             s2_load;
	logic             s2_fault;
	logic             s2_wpend;

	// memories
	logic             rf_we;
	logic [RF_AW-1:0] rf_waddr;
	logic [31:0]      rf_wdata;
	logic [RF_AW-1:0] rf_braddr;
	logic [31:0]      rfa_rdata;
	logic [31:0]      rfb_rdata;
	logic               dm_we;
	logic [DMEM_AW-1:0] dm_waddr;
	logic [31:0]        dm_wdata;
	logic [31:0]        dm_rdata;

	// execute
	logic [31:0] opa;
	logic [31:0] opb;
	logic [31:0] result_value;
	exec_res_t   res;

	// configuration port: always ready, read mux on register index
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			CFG_IDX_START: prdata = {16'b0, start_q};
			CFG_IDX_BASE:  prdata = {16'b0, base_q};
			default:       prdata = '0;
		endcase
	end

	// configuration registers and program counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
			base_q  <= BASE_RESET;
			pc_q    <= START_RESET;
		end else begin
			if (adv12) begin
				pc_q <= res.pc_next;
			end
			if (cfg_wr) begin
				case (paddr[2])
					CFG_IDX_START: begin
						start_q <= pwdata[15:0];
						pc_q    <= pwdata[15:0];
					end
					CFG_IDX_BASE: begin
						base_q <= pwdata[15:0];
					end
					default: begin
						base_q <= base_q;
					end
				endcase
			end
		end
	end

	// sweep both stores to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == CLR_AW'(CLR_WORDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// handshake: each stage moves when the next one is free
	assign s2_free   = !s2_valid || !out_stall;
	assign adv12     = s1_valid && s2_free;
	assign in_stall  = clearing_q || (s1_valid && !adv12);
	assign in_accept = in_valid && !in_stall;

	// stage valid flags and pending register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
			s2_wpend <= 1'b0;
		end else begin
			if (in_accept) begin
				s1_valid <= 1'b1;
			end else if (adv12) begin
				s1_valid <= 1'b0;
			end
			if (adv12) begin
				s2_valid <= 1'b1;
			end else if (!out_stall) begin
				s2_valid <= 1'b0;
			end
			s2_wpend <= adv12 && res.reg_wr;
		end
	end

	// capture the transaction into the input stage
	always_ff @(posedge clk) begin
		if (in_accept) begin
			s1_kind   <= kind;
			s1_dest   <= dest_reg;
			s1_src    <= src_reg;
			s1_breg   <= rf_braddr;
			s1_imm    <= immediate;
			s1_target <= branch_target;
			s1_data   <= data_value;
		end
	end

	// track register writes that land at or after the operand read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			patch_a_q <= 1'b0;
			patch_b_q <= 1'b0;
		end else if (in_accept) begin
			patch_a_q <= rf_we && (rf_waddr == src_reg);
			patch_b_q <= rf_we && (rf_waddr == rf_braddr);
		end else begin
			if (rf_we && (rf_waddr == s1_src)) begin
				patch_a_q <= 1'b1;
			end
			if (rf_we && (rf_waddr == s1_breg)) begin
				patch_b_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			patch_a_val_q <= rf_wdata;
			patch_b_val_q <= rf_wdata;
		end else begin
			if (rf_we && (rf_waddr == s1_src)) begin
				patch_a_val_q <= rf_wdata;
			end
			if (rf_we && (rf_waddr == s1_breg)) begin
				patch_b_val_q <= rf_wdata;
			end
		end
	end

	// operands: newest write first, then captured patch, then RAM data
	always_comb begin
		if (rf_we && (rf_waddr == s1_src)) begin
			opa = rf_wdata;
		end else if (patch_a_q) begin
			opa = patch_a_val_q;
		end else begin
			opa = rfa_rdata;
		end
		if (rf_we && (rf_waddr == s1_breg)) begin
			opb = rf_wdata;
		end else if (patch_b_q) begin
			opb = patch_b_val_q;
		end else begin
			opb = rfb_rdata;
		end
	end

	lse_exec u_exec (
		.kind          (s1_kind),
		.dest_reg      (s1_dest),
		.immediate     (s1_imm),
		.branch_target (s1_target),
		.data_value    (s1_data),
		.opa           (opa),
		.opb           (opb),
		.pc            (pc_q),
		.data_base     (base_q),
		.res           (res)
	);

	// result stage payload
	always_ff @(posedge clk) begin
		if (adv12) begin
			s2_pc    <= res.pc_next;
			s2_wr    <= res.reg_wr;
			s2_idx   <= res.wr_index;
			s2_val   <= res.alu_value;
			s2_load  <= res.is_load;
			s2_fault <= res.fault;
		end
	end

	assign result_value = s2_load ? dm_rdata : s2_val;

	// register file: two copies, one per read port, written together
	assign rf_braddr = (kind == KIND_STUR) ? dest_reg : second_reg;

	always_comb begin
		if (clearing_q) begin
			rf_we    = 32'(clr_cnt_q) < 32'(NUM_REGS);
			rf_waddr = clr_cnt_q[RF_AW-1:0];
			rf_wdata = '0;
		end else begin
			rf_we    = s2_wpend;
			rf_waddr = s2_idx;
			rf_wdata = result_value;
		end
	end

	lse_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (in_accept),
		.raddr (src_reg),
		.rdata (rfa_rdata)
	);

	lse_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (in_accept),
		.raddr (rf_braddr),
		.rdata (rfb_rdata)
	);

	// data memory: stores and preloads write as the instruction leaves stage 1
	always_comb begin
		if (clearing_q) begin
			dm_we    = 32'(clr_cnt_q) < 32'(DATA_WORDS);
			dm_waddr = clr_cnt_q[DMEM_AW-1:0];
			dm_wdata = '0;
		end else begin
			dm_we    = adv12 && res.dmem_we;
			dm_waddr = res.dmem_addr;
			dm_wdata = res.dmem_wdata;
		end
	end

	lse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.re    (adv12 && res.dmem_re),
		.raddr (res.dmem_addr),
		.rdata (dm_rdata)
	);

	// result channel
	assign out_valid     = s2_valid;
	assign pc_after      = s2_pc;
	assign reg_written   = s2_wr;
	assign written_index = s2_idx;
	assign written_value = result_value;
	assign access_fault  = s2_fault;

endmodule
`default_nettype wire
